// File: rtl/lru_pkg.sv
// shared constants, opcode and status codes for the lru list engine
package lru_pkg;

   localparam int LRU_NUM_ENTRIES = 1024;
   localparam int LRU_IDX_W       = $clog2(LRU_NUM_ENTRIES);
   localparam int LRU_CNT_W       = $clog2(LRU_NUM_ENTRIES + 1);

   localparam int LRU_OP_W     = 3;
   localparam int LRU_STATUS_W = 3;
   localparam int LRU_PADDR_W  = 3;
   localparam int LRU_PDATA_W  = 32;

   // register index, taken from paddr above the byte lanes
   localparam logic [LRU_PADDR_W-3:0] REG_ENTRIES_IN_USE = '0;

   typedef enum logic [LRU_OP_W-1:0] {
      OP_INSERT_HEAD = 3'd0,
      OP_INSERT_TAIL = 3'd1,
      OP_REMOVE      = 3'd2,
      OP_TOUCH       = 3'd3,
      OP_POP_HEAD    = 3'd4,
      OP_POP_TAIL    = 3'd5,
      OP_CLEAR       = 3'd6,
      OP_QUERY       = 3'd7
   } op_type;

   typedef enum logic [LRU_STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_RANGE     = 3'd1,
      ST_USED      = 3'd2,
      ST_NOT_USED  = 3'd3,
      ST_EMPTY     = 3'd4
   } status_type;

endpackage

// File: rtl/lru_if.sv
// request and response channel interfaces of the lru list engine
interface lru_req_if import lru_pkg::*; #(
   parameter int IDX_W = LRU_IDX_W
);
   logic                valid;
   logic                ready;
   logic [LRU_OP_W-1:0] opcode;
   logic [IDX_W-1:0]    entry_index;

   modport source (output valid, opcode, entry_index, input ready);
   modport sink   (input valid, opcode, entry_index, output ready);
endinterface

interface lru_rsp_if import lru_pkg::*; #(
   parameter int IDX_W = LRU_IDX_W,
   parameter int CNT_W = LRU_CNT_W
);
   logic                    valid;
   logic                    ready;
   logic [LRU_STATUS_W-1:0] status;
   logic [IDX_W-1:0]        popped_index;
   logic                    entry_used;
   logic [IDX_W-1:0]        head_index;
   logic [IDX_W-1:0]        tail_index;
   logic                    list_nonempty;
   logic [CNT_W-1:0]        used_count;
   logic                    list_full;

   modport source (output valid, status, popped_index, entry_used, head_index, tail_index,
                   list_nonempty, used_count, list_full, input ready);
   modport sink   (input valid, status, popped_index, entry_used, head_index, tail_index,
                   list_nonempty, used_count, list_full, output ready);
endinterface

// File: rtl/lru_linked_list_engine.sv
// lru list engine: recency list kept as index links in two synchronous memories
//
// channel   dir  handshake           beat contents
// req_bus   in   valid/ready         opcode, entry_index
// rsp_bus   out  valid/ready         status, popped index, used flag, head, tail, count, flags
// apb       in   psel/penable/pready entries_in_use at byte address 0
//
// sequence: each request is read and decided in a lookup; insert, remove and pop may add a step
//   for the second neighbor link write, touch may add steps too (touch of the head writes nothing,
//   a mid-list touch also fixes the next neighbor); clear ends in the used-flag sweep through the
//   next-link memory
// reset: synchronous; afterwards the used flags are swept to zero with req_bus.ready low
//   (register writes are still taken)
// stalls: the result sits in an output register, so a new request is taken while it waits;
//   a finished lookup only holds when that register is still full
// all link writes finish before the next request is accepted, so reads never see stale data
module lru_linked_list_engine import lru_pkg::*; #(
   parameter int NUM_ENTRIES = LRU_NUM_ENTRIES,
   parameter int IDX_W       = $clog2(NUM_ENTRIES),
   parameter int CNT_W       = $clog2(NUM_ENTRIES + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   lru_req_if.sink                req_bus,
   lru_rsp_if.source              rsp_bus,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [LRU_PADDR_W-1:0] paddr,
   input  logic [LRU_PDATA_W-1:0] pwdata,
   output logic [LRU_PDATA_W-1:0] prdata,
   output logic                   pready
);

   localparam int NXT_W = IDX_W + 2;   // {used, next valid, next link}
   localparam int PRV_W = IDX_W + 1;   // {prev valid, prev link}
   localparam logic [CNT_W-1:0] NUM_CNT  = CNT_W'(NUM_ENTRIES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ENTRIES - 1);

   // one memory write slot for each of the two link memories
   typedef struct packed {
      logic             a_en;
      logic [IDX_W-1:0] a_addr;
      logic [NXT_W-1:0] a_data;
      logic             b_en;
      logic [IDX_W-1:0] b_addr;
      logic [PRV_W-1:0] b_data;
   } wr_type;

   typedef enum logic [4:0] {
      S_SWEEP = 5'b00001,
      S_IDLE  = 5'b00010,
      S_LOOK  = 5'b00100,
      S_STEP2 = 5'b01000,
      S_STEP3 = 5'b10000
   } state_type;

   // link memories: next side also carries the used flag
   logic [NXT_W-1:0] next_mem [NUM_ENTRIES];
   logic [PRV_W-1:0] prev_mem [NUM_ENTRIES];

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] sweep_ff, sweep_in;
   op_type           op_ff, op_in;
   logic [IDX_W-1:0] addr_ff, addr_in;
   logic [NXT_W-1:0] next_rd_ff;
   logic [PRV_W-1:0] prev_rd_ff;
   wr_type           step2_ff, step2_in;
   wr_type           step3_ff, step3_in;

   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic             nonempty_ff, nonempty_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] limit_ff, limit_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [LRU_STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [IDX_W-1:0]        rsp_popped_ff, rsp_popped_in;
   logic                    rsp_used_ff, rsp_used_in;
   logic [IDX_W-1:0]        rsp_head_ff, rsp_head_in;
   logic [IDX_W-1:0]        rsp_tail_ff, rsp_tail_in;
   logic                    rsp_nonempty_ff, rsp_nonempty_in;
   logic [CNT_W-1:0]        rsp_count_ff, rsp_count_in;
   logic                    rsp_full_ff, rsp_full_in;

   logic             accept;
   logic             rsp_free;
   logic             commit;
   logic             cfg_write;
   logic             cfg_hit;
   logic [CNT_W-1:0] eff_limit;
   wr_type           cur_wr;

   // lookup decode
   logic             rd_used, rd_nv, rd_pv;
   logic [IDX_W-1:0] rd_next, rd_prev;
   logic             named, in_range, idx_exists;
   logic             do_unlink, used_after;
   status_type       look_status;
   logic [IDX_W-1:0] look_popped;
   logic [IDX_W-1:0] look_head, look_tail;
   logic             look_nonempty;
   logic [CNT_W-1:0] look_count;
   wr_type           look_s1, look_s2, look_s3;
   state_type        look_next;

   assign {rd_used, rd_nv, rd_next} = next_rd_ff;
   assign {rd_pv, rd_prev}          = prev_rd_ff;

   // ---------------- configuration port ----------------
   assign pready    = 1'b1;
   assign cfg_hit   = (paddr[LRU_PADDR_W-1:2] == REG_ENTRIES_IN_USE);
   assign cfg_write = psel && penable && pwrite && pready && cfg_hit;
   assign limit_in  = cfg_write ? pwdata[CNT_W-1:0] : limit_ff;
   assign prdata    = cfg_hit ? LRU_PDATA_W'(limit_ff) : '0;

   // limit saturates at the table depth
   assign eff_limit = (limit_ff > NUM_CNT) ? NUM_CNT : limit_ff;

   // ---------------- handshakes ----------------
   assign req_bus.ready = (state_ff == S_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;
   assign rsp_free      = !rsp_valid_ff || rsp_bus.ready;
   assign commit        = (state_ff == S_LOOK) && rsp_free;

   // pops read the link word of the current head or tail instead of the named entry
   always_comb begin
      op_in   = op_ff;
      addr_in = addr_ff;
      if (accept) begin
         op_in = op_type'(req_bus.opcode);
         case (op_type'(req_bus.opcode))
            OP_POP_HEAD: addr_in = head_ff;
            OP_POP_TAIL: addr_in = tail_ff;
            default:     addr_in = req_bus.entry_index;
         endcase
      end
   end

   // ---------------- lookup: decide the update from the read links ----------------
   always_comb begin
      named       = op_ff inside {OP_INSERT_HEAD, OP_INSERT_TAIL, OP_REMOVE, OP_TOUCH, OP_QUERY};
      in_range    = (CNT_W'(addr_ff) < eff_limit);
      idx_exists  = (CNT_W'(addr_ff) < NUM_CNT);
      do_unlink   = 1'b0;
      used_after  = rd_used;
      look_status = ST_OK;
      look_popped = '0;
      look_head     = head_ff;
      look_tail     = tail_ff;
      look_nonempty = nonempty_ff;
      look_count    = count_ff;
      look_s1     = '0;
      look_s2     = '0;
      look_s3     = '0;
      look_next   = S_IDLE;

      if (named && !in_range) begin
         look_status = ST_RANGE;
      end else begin
         case (op_ff)
            OP_INSERT_HEAD: begin
               if (rd_used) begin
                  look_status = ST_USED;
               end else begin
                  used_after = 1'b1;
                  look_s1.a_en   = 1'b1;
                  look_s1.a_addr = addr_ff;
                  look_s1.a_data = {1'b1, nonempty_ff, nonempty_ff ? head_ff : '0};
                  look_s1.b_en   = 1'b1;
                  look_s1.b_addr = addr_ff;
                  look_s1.b_data = '0;
                  // old head gains a prev link
                  look_s2.b_en   = nonempty_ff;
                  look_s2.b_addr = head_ff;
                  look_s2.b_data = {1'b1, addr_ff};
                  look_head      = addr_ff;
                  look_tail      = nonempty_ff ? tail_ff : addr_ff;
                  look_nonempty  = 1'b1;
                  look_count     = count_ff + 1'b1;
               end
            end
            OP_INSERT_TAIL: begin
               if (rd_used) begin
                  look_status = ST_USED;
               end else begin
                  used_after = 1'b1;
                  look_s1.a_en   = 1'b1;
                  look_s1.a_addr = addr_ff;
                  look_s1.a_data = {1'b1, 1'b0, IDX_W'(0)};
                  look_s1.b_en   = 1'b1;
                  look_s1.b_addr = addr_ff;
                  look_s1.b_data = {nonempty_ff, nonempty_ff ? tail_ff : '0};
                  // old tail gains a next link, keeps its used flag
                  look_s2.a_en   = nonempty_ff;
                  look_s2.a_addr = tail_ff;
                  look_s2.a_data = {1'b1, 1'b1, addr_ff};
                  look_tail      = addr_ff;
                  look_head      = nonempty_ff ? head_ff : addr_ff;
                  look_nonempty  = 1'b1;
                  look_count     = count_ff + 1'b1;
               end
            end
            OP_REMOVE: begin
               if (!rd_used) begin
                  look_status = ST_NOT_USED;
               end else begin
                  do_unlink  = 1'b1;
                  used_after = 1'b0;
               end
            end
            OP_TOUCH: begin
               if (!rd_used) begin
                  look_status = ST_NOT_USED;
               end else if (addr_ff != head_ff) begin
                  // not the head, so a prev link exists; unlink and relink at the head
                  look_s1.a_en   = 1'b1;
                  look_s1.a_addr = addr_ff;
                  look_s1.a_data = {1'b1, 1'b1, head_ff};
                  look_s1.b_en   = 1'b1;
                  look_s1.b_addr = addr_ff;
                  look_s1.b_data = '0;
                  look_s2.a_en   = 1'b1;
                  look_s2.a_addr = rd_prev;
                  look_s2.a_data = {1'b1, rd_nv, rd_next};
                  look_s2.b_en   = 1'b1;
                  look_s2.b_addr = head_ff;
                  look_s2.b_data = {1'b1, addr_ff};
                  look_s3.b_en   = rd_nv;
                  look_s3.b_addr = rd_next;
                  look_s3.b_data = {1'b1, rd_prev};
                  look_head      = addr_ff;
                  look_tail      = rd_nv ? tail_ff : rd_prev;
               end
            end
            OP_POP_HEAD, OP_POP_TAIL: begin
               if (!nonempty_ff) begin
                  look_status = ST_EMPTY;
               end else begin
                  look_popped = addr_ff;
                  do_unlink   = 1'b1;
               end
            end
            OP_CLEAR: begin
               look_head     = '0;
               look_tail     = '0;
               look_nonempty = 1'b0;
               look_count    = '0;
               look_next     = S_SWEEP;
            end
            default: begin
               // query: no change
            end
         endcase
      end

      if (do_unlink) begin
         look_s1.a_en   = 1'b1;
         look_s1.a_addr = addr_ff;
         look_s1.a_data = '0;
         look_s1.b_en   = rd_nv;
         look_s1.b_addr = rd_next;
         look_s1.b_data = {rd_pv, rd_prev};
         look_s2.a_en   = rd_pv;
         look_s2.a_addr = rd_prev;
         look_s2.a_data = {1'b1, rd_nv, rd_next};
         look_head      = rd_pv ? head_ff : (rd_nv ? rd_next : '0);
         look_tail      = rd_nv ? tail_ff : (rd_pv ? rd_prev : '0);
         look_nonempty  = rd_pv || rd_nv;
         look_count     = (count_ff != '0) ? count_ff - 1'b1 : count_ff;
      end

      if (look_next != S_SWEEP) begin
         if (look_s2.a_en || look_s2.b_en) begin
            look_next = S_STEP2;
         end
      end
   end

   // ---------------- sequencer ----------------
   always_comb begin
      state_in = state_ff;
      sweep_in = sweep_ff;
      step2_in = step2_ff;
      step3_in = step3_ff;
      cur_wr   = '0;
      case (state_ff)
         S_SWEEP: begin
            cur_wr.a_en   = 1'b1;
            cur_wr.a_addr = sweep_ff;
            cur_wr.a_data = '0;
            if (sweep_ff == LAST_IDX) begin
               sweep_in = '0;
               state_in = S_IDLE;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (accept) begin
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            if (commit) begin
               cur_wr   = look_s1;
               step2_in = look_s2;
               step3_in = look_s3;
               state_in = look_next;
            end
         end
         S_STEP2: begin
            cur_wr   = step2_ff;
            state_in = step3_ff.b_en ? S_STEP3 : S_IDLE;
         end
         S_STEP3: begin
            cur_wr   = step3_ff;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // list registers and the result take their new values at commit
   always_comb begin
      head_in      = commit ? look_head     : head_ff;
      tail_in      = commit ? look_tail     : tail_ff;
      nonempty_in  = commit ? look_nonempty : nonempty_ff;
      count_in     = commit ? look_count    : count_ff;

      rsp_valid_in    = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in   = rsp_status_ff;
      rsp_popped_in   = rsp_popped_ff;
      rsp_used_in     = rsp_used_ff;
      rsp_head_in     = rsp_head_ff;
      rsp_tail_in     = rsp_tail_ff;
      rsp_nonempty_in = rsp_nonempty_ff;
      rsp_count_in    = rsp_count_ff;
      rsp_full_in     = rsp_full_ff;
      if (commit) begin
         rsp_valid_in    = 1'b1;
         rsp_status_in   = look_status;
         rsp_popped_in   = look_popped;
         rsp_used_in     = named && idx_exists && used_after;
         rsp_head_in     = look_head;
         rsp_tail_in     = look_tail;
         rsp_nonempty_in = look_nonempty;
         rsp_count_in    = look_count;
         rsp_full_in     = (look_count == eff_limit);
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.status        = rsp_status_ff;
   assign rsp_bus.popped_index  = rsp_popped_ff;
   assign rsp_bus.entry_used    = rsp_used_ff;
   assign rsp_bus.head_index    = rsp_head_ff;
   assign rsp_bus.tail_index    = rsp_tail_ff;
   assign rsp_bus.list_nonempty = rsp_nonempty_ff;
   assign rsp_bus.used_count    = rsp_count_ff;
   assign rsp_bus.list_full     = rsp_full_ff;

   // ---------------- link memories ----------------
   always_ff @(posedge clock) begin
      if (cur_wr.a_en) begin
         next_mem[cur_wr.a_addr] <= cur_wr.a_data;
      end
      if (accept) begin
         next_rd_ff <= next_mem[addr_in];
      end
   end

   always_ff @(posedge clock) begin
      if (cur_wr.b_en) begin
         prev_mem[cur_wr.b_addr] <= cur_wr.b_data;
      end
      if (accept) begin
         prev_rd_ff <= prev_mem[addr_in];
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         sweep_ff     <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         nonempty_ff  <= 1'b0;
         count_ff     <= '0;
         limit_ff     <= NUM_CNT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         nonempty_ff  <= nonempty_in;
         count_ff     <= count_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff           <= op_in;
      addr_ff         <= addr_in;
      step2_ff        <= step2_in;
      step3_ff        <= step3_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_popped_ff   <= rsp_popped_in;
      rsp_used_ff     <= rsp_used_in;
      rsp_head_ff     <= rsp_head_in;
      rsp_tail_ff     <= rsp_tail_in;
      rsp_nonempty_ff <= rsp_nonempty_in;
      rsp_count_ff    <= rsp_count_in;
      rsp_full_ff     <= rsp_full_in;
   end

   // ---------------- assertions ----------------
   // link writes must be done before a request reads the memories
   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !cur_wr.a_en && !cur_wr.b_en)
      else $error("link memory written while a request can be accepted");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= NUM_CNT)
      else $error("entry count above table depth");

   a_nonempty_count: assert property (@(posedge clock) disable iff (reset)
      nonempty_ff == (count_ff != '0))
      else $error("non-empty flag disagrees with entry count");

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      !nonempty_ff |-> head_ff == '0 && tail_ff == '0)
      else $error("head or tail nonzero on an empty list");

   a_commit_one: assert property (@(posedge clock) disable iff (reset)
      commit |=> state_ff != S_LOOK)
      else $error("lookup state held after commit");

endmodule
